### sv/gpn_pkg.sv
// package: constants, types and tables for the gaussian profile normalizer
`default_nettype none
package gpn_pkg;
    localparam int unsigned MAX_NODES_DEF = 64;
    localparam int unsigned CFG_W = 16;
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPREAD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPACING = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AREA = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT = 3'd4;
    localparam logic [16:0] LOG2E_Q16 = 17'd94548;

    typedef struct packed {
        logic div_start;
        logic div_mode;
        logic wr_weight;
        logic acc_clear;
        logic acc_add;
        logic load_q;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic div_done;
    } t_sts;

    function automatic logic [16:0] pow2_lookup(input logic [4:0] j);
        logic [16:0] v;
        begin
            case (j)
                5'd0: v = 17'd65536;  5'd1: v = 17'd62757;
                5'd2: v = 17'd60097;  5'd3: v = 17'd57549;
                5'd4: v = 17'd55108;  5'd5: v = 17'd52773;
                5'd6: v = 17'd50535;  5'd7: v = 17'd48392;
                5'd8: v = 17'd46341;  5'd9: v = 17'd44376;
                5'd10: v = 17'd42495; 5'd11: v = 17'd40693;
                5'd12: v = 17'd38968; 5'd13: v = 17'd37316;
                5'd14: v = 17'd35734; 5'd15: v = 17'd34219;
                default: v = 17'd32768;
            endcase
            return v;
        end
    endfunction
endpackage
`default_nettype wire

### sv/gpn_ram.sv
// generic single port ram with registered read
`default_nettype none
module gpn_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

### sv/gpn_datapath.sv
// datapath: weight evaluation, simpson sum, serial divider, output register
`default_nettype none
module gpn_datapath #(
    parameter int unsigned MAX_NODES = gpn_pkg::MAX_NODES_DEF,
    parameter int unsigned IDX_W = $clog2(MAX_NODES)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire gpn_pkg::t_cmd     i_cmd,
    input  wire logic [IDX_W-1:0]  i_node,
    input  wire logic              i_is_end,
    input  wire logic              i_is_last,
    input  wire logic [15:0]       i_peak,
    input  wire logic [15:0]       i_spread,
    input  wire logic [15:0]       i_spacing,
    input  wire logic [15:0]       i_area,
    output gpn_pkg::t_sts          o_sts,
    output logic [5:0]             o_node_index,
    output logic [15:0]            o_density,
    output logic                   o_last
);
    import gpn_pkg::*;

    // shared restoring divider: 62 bit numerator, 48 bit denominator
    localparam int unsigned NUM_W = 62;
    localparam int unsigned DEN_W = 48;
    localparam int unsigned CNT_W = 6;

    logic [NUM_W-1:0] r_quo, n_quo;
    logic [DEN_W:0]   r_rem, n_rem;
    logic [DEN_W-1:0] r_den, n_den;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done;
    logic [31:0]      r_acc;
    logic [47:0]      r_q;
    logic [19:0]      r_x;
    logic [21:0]      r_y;
    logic             r_far1, r_far2;
    logic [15:0]      r_weight;
    logic [15:0]      w_rd;
    logic [15:0]      w_weight;
    logic [IDX_W+15:0] w_pos;
    logic [IDX_W+15:0] w_d;
    logic [DEN_W:0]   w_trial;
    logic [17:0]      w_t;
    logic [35:0]      w_tt;
    logic [37:0]      w_xy;
    logic [5:0]       w_k;
    logic [3:0]       w_j;
    logic [11:0]      w_r;
    logic [16:0]      w_ta, w_tb, w_m;
    logic [29:0]      w_dr;
    logic [16:0]      w_ms;
    logic [2:0]       w_c;

    assign w_pos = (IDX_W+16)'(i_node) * (IDX_W+16)'(i_spacing);
    assign w_d = (w_pos >= (IDX_W+16)'(i_peak)) ? w_pos - (IDX_W+16)'(i_peak)
                                                : (IDX_W+16)'(i_peak) - w_pos;

    always_comb begin
        n_quo = r_quo;
        n_rem = r_rem;
        n_den = r_den;
        n_cnt = r_cnt;
        n_busy = r_busy;
        w_trial = '0;
        if (i_cmd.div_start) begin
            n_busy = 1'b1;
            n_cnt = CNT_W'(NUM_W - 1);
            n_rem = '0;
            if (i_cmd.div_mode) begin
                n_quo = NUM_W'({32'd0, i_area} * {16'd0, w_rd} * 48'd768) + NUM_W'(r_q >> 1);
                n_den = r_q;
            end else begin
                n_quo = NUM_W'({w_d, 16'd0});
                n_den = (i_spread == 16'd0) ? DEN_W'(1) : DEN_W'(i_spread);
            end
        end else if (r_busy) begin
            w_trial = {r_rem[DEN_W-1:0], r_quo[NUM_W-1]};
            if (w_trial >= {1'b0, r_den}) begin
                n_rem = w_trial - {1'b0, r_den};
                n_quo = {r_quo[NUM_W-2:0], 1'b1};
            end else begin
                n_rem = w_trial;
                n_quo = {r_quo[NUM_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == '0) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_acc <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= r_busy && !n_busy;
            if (i_cmd.acc_clear) begin
                r_acc <= '0;
            end else if (i_cmd.acc_add) begin
                r_acc <= r_acc + 32'(w_c) * 32'(r_weight);
            end
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
        r_cnt <= n_cnt;
        if (i_cmd.load_q) begin
            r_q <= {32'd0, i_spacing} * {16'd0, r_acc};
        end
    end

    // exp approximation from the quotient t, three register stages
    assign w_t = r_quo[17:0];
    assign w_tt = w_t * w_t;
    assign w_xy = 38'(r_x) * 38'(LOG2E_Q16) + 38'd32768;
    assign w_k = r_y[21:16];
    assign w_j = r_y[15:12];
    assign w_r = r_y[11:0];
    assign w_ta = pow2_lookup({1'b0, w_j});
    assign w_tb = pow2_lookup({1'b0, w_j} + 5'd1);
    assign w_dr = 30'(w_ta - w_tb) * 30'(w_r) + 30'd2048;
    assign w_m = w_ta - 17'(w_dr[29:12]);
    assign w_ms = (w_k == 6'd0) ? w_m : ((w_m + (17'd1 << (w_k - 6'd1))) >> w_k);

    always_comb begin
        if (r_far2 || w_k >= 6'd17) begin
            w_weight = 16'd0;
        end else if (w_ms > 17'd65535) begin
            w_weight = 16'hFFFF;
        end else begin
            w_weight = w_ms[15:0];
        end
        if (i_node[0]) begin
            w_c = i_is_end ? 3'd3 : 3'd4;
        end else begin
            w_c = i_is_end ? 3'd1 : 3'd2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= w_tt[35:16];
        r_far1 <= r_quo[NUM_W-1:18] != '0;
        r_y <= w_xy[37:16];
        r_far2 <= r_far1;
        r_weight <= w_weight;
    end

    gpn_ram #(.WIDTH(16), .DEPTH(MAX_NODES)) u_store (
        .i_clk  (i_clk),
        .i_we   (i_cmd.wr_weight),
        .i_addr (i_node),
        .i_wdata(r_weight),
        .o_rdata(w_rd)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_node_index <= 6'(i_node);
            o_last <= i_is_last;
            if (r_q == '0) begin
                o_density <= 16'd0;
            end else if (r_quo[NUM_W-1:16] != '0) begin
                o_density <= 16'hFFFF;
            end else begin
                o_density <= r_quo[15:0];
            end
        end
    end

    assign o_sts.div_done = r_done;
endmodule
`default_nettype wire

### sv/gpn_ctrl.sv
// controller: sequences the weight pass, the sum and the density pass
`default_nettype none
module gpn_ctrl #(
    parameter int unsigned MAX_NODES = gpn_pkg::MAX_NODES_DEF,
    parameter int unsigned IDX_W = $clog2(MAX_NODES)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [6:0]       i_count,
    input  wire logic             i_out_stall,
    input  wire gpn_pkg::t_sts    i_sts,
    output gpn_pkg::t_cmd         o_cmd,
    output logic [IDX_W-1:0]      o_node,
    output logic                  o_is_end,
    output logic                  o_is_last,
    output logic                  o_busy,
    output logic                  o_out_valid
);
    import gpn_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_WSTART = 4'd1;
    localparam logic [3:0] S_WDIV = 4'd2;
    localparam logic [3:0] S_WEXP1 = 4'd3;
    localparam logic [3:0] S_WEXP2 = 4'd4;
    localparam logic [3:0] S_WSTORE = 4'd5;
    localparam logic [3:0] S_QLOAD = 4'd6;
    localparam logic [3:0] S_READ = 4'd7;
    localparam logic [3:0] S_DDIV = 4'd8;
    localparam logic [3:0] S_OUT = 4'd9;

    logic [3:0]       r_state, n_state;
    logic [IDX_W-1:0] r_node, n_node;
    logic [IDX_W:0]   r_last_idx, n_last_idx;
    logic             r_valid, n_valid;
    logic             r_go;

    always_comb begin
        n_state = r_state;
        n_node = r_node;
        n_last_idx = r_last_idx;
        n_valid = r_valid;
        o_cmd = '0;
        if (r_valid && !i_out_stall) begin
            n_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_count < 7'd3) begin
                        n_last_idx = (IDX_W+1)'(2);
                    end else if (32'(i_count) > MAX_NODES) begin
                        n_last_idx = (IDX_W+1)'(MAX_NODES - 1);
                    end else begin
                        n_last_idx = (IDX_W+1)'(i_count - 7'd1);
                    end
                    n_node = '0;
                    o_cmd.acc_clear = 1'b1;
                    n_state = S_WSTART;
                end
            end
            S_WSTART: begin
                o_cmd.div_start = 1'b1;
                n_state = S_WDIV;
            end
            S_WDIV: begin
                if (i_sts.div_done) begin
                    n_state = S_WEXP1;
                end
            end
            S_WEXP1: begin
                n_state = S_WEXP2;
            end
            S_WEXP2: begin
                n_state = S_WSTORE;
            end
            S_WSTORE: begin
                o_cmd.wr_weight = 1'b1;
                o_cmd.acc_add = 1'b1;
                if ((IDX_W+1)'(r_node) == r_last_idx) begin
                    n_state = S_QLOAD;
                end else begin
                    n_node = r_node + IDX_W'(1);
                    n_state = S_WSTART;
                end
            end
            S_QLOAD: begin
                o_cmd.load_q = 1'b1;
                n_node = '0;
                n_state = S_READ;
            end
            S_READ: begin
                if (r_go) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_mode = 1'b1;
                    n_state = S_DDIV;
                end
            end
            S_DDIV: begin
                if (i_sts.div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_valid = 1'b1;
                    if ((IDX_W+1)'(r_node) == r_last_idx) begin
                        n_state = S_IDLE;
                    end else begin
                        n_node = r_node + IDX_W'(1);
                        n_state = S_READ;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_node <= '0;
            r_last_idx <= '0;
            r_valid <= 1'b0;
            r_go <= 1'b0;
        end else begin
            r_state <= n_state;
            r_node <= n_node;
            r_last_idx <= n_last_idx;
            r_valid <= n_valid;
            r_go <= (r_state == S_READ) && !r_go;
        end
    end

    assign o_node = r_node;
    assign o_is_end = (r_node == '0) || ((IDX_W+1)'(r_node) == r_last_idx);
    assign o_is_last = (IDX_W+1)'(r_node) == r_last_idx;
    assign o_busy = r_state != S_IDLE;
    assign o_out_valid = r_valid;
endmodule
`default_nettype wire

### sv/gaussian_profile_normalizer.sv
// top level: gaussian profile normalizer with simpson normalization
//  channel   dir  handshake            payload
//  input     in   i_valid / o_stall    i_request
//  output    out  o_valid / i_stall    o_node_index, o_density, o_last
//  config    in   i_cfg_we             i_cfg_index, i_cfg_data
// a run of n nodes keeps the block busy for a weight pass and then a density pass over
// all nodes, both paced by the one bit per cycle shared divider (62 steps); the weight
// pass also runs each quotient through the three stage exp approximation
// reset is synchronous active low; it clears the control state and sets config defaults
// input is stalled for the whole run; output stall holds the finished density
`default_nettype none
module gaussian_profile_normalizer #(
    parameter int unsigned MAX_NODES = gpn_pkg::MAX_NODES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic                          i_request,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [5:0]                         o_node_index,
    output logic [15:0]                        o_density,
    output logic                               o_last,
    input  wire logic                          i_cfg_we,
    input  wire logic [gpn_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [gpn_pkg::CFG_W-1:0]     i_cfg_data
);
    import gpn_pkg::*;
    localparam int unsigned IDX_W = $clog2(MAX_NODES);

    logic [15:0] r_peak, r_spread, r_spacing, r_area;
    logic [6:0]  r_count;
    t_cmd        w_cmd;
    t_sts        w_sts;
    logic [IDX_W-1:0] w_node;
    logic        w_is_end, w_is_last, w_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak <= 16'd128;
            r_spread <= 16'd64;
            r_spacing <= 16'd256;
            r_area <= 16'd4096;
            r_count <= 7'd64;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PEAK: r_peak <= i_cfg_data;
                REG_SPREAD: r_spread <= i_cfg_data;
                REG_SPACING: r_spacing <= i_cfg_data;
                REG_AREA: r_area <= i_cfg_data;
                REG_COUNT: r_count <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    assign o_stall = w_busy;

    gpn_ctrl #(.MAX_NODES(MAX_NODES), .IDX_W(IDX_W)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_valid && !w_busy && i_request),
        .i_count    (r_count),
        .i_out_stall(i_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_node     (w_node),
        .o_is_end   (w_is_end),
        .o_is_last  (w_is_last),
        .o_busy     (w_busy),
        .o_out_valid(o_valid)
    );

    gpn_datapath #(.MAX_NODES(MAX_NODES), .IDX_W(IDX_W)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_node      (w_node),
        .i_is_end    (w_is_end),
        .i_is_last   (w_is_last),
        .i_peak      (r_peak),
        .i_spread    (r_spread),
        .i_spacing   (r_spacing),
        .i_area      (r_area),
        .o_sts       (w_sts),
        .o_node_index(o_node_index),
        .o_density   (o_density),
        .o_last      (o_last)
    );
endmodule
`default_nettype wire

### sv/gpn_checker.sv
// port checker for the gaussian profile normalizer
`default_nettype none
module gpn_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic        i_request,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [5:0]  o_node_index,
    input wire logic [15:0] o_density,
    input wire logic        o_last
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_density) && $stable(o_node_index))
        else $error("stalled transaction changed");
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_last |=> !o_valid)
        else $error("transaction after last");
    a_req_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_request |=> o_stall)
        else $error("request did not start a run");
    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result outside a run");
endmodule

bind gaussian_profile_normalizer gpn_checker u_gpn_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .i_request   (i_request),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_node_index(o_node_index),
    .o_density   (o_density),
    .o_last      (o_last)
);
`default_nettype wire

### test/gaussian_profile_normalizer_tb.sv
// testbench: gaussian profile normalizer, scoreboard checked against an in-bench predictor
`timescale 1ns / 100ps
`default_nettype none
module gaussian_profile_normalizer_tb;
    import gpn_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct {
        logic [5:0]  node_index;
        logic [15:0] density;
        logic        last;
    } t_density;

    class profile_scoreboard;
        logic [15:0] peak_height = 16'd128;
        logic [15:0] spread = 16'd64;
        logic [15:0] node_spacing = 16'd256;
        logic [15:0] leaf_area = 16'd4096;
        logic [6:0]  node_count = 7'd64;
        logic [15:0] weight_store [64];
        logic [31:0] integral_acc = 32'd0;
        t_density    pending [$];
        int          errors = 0;

        function logic [31:0] pow2_entry(int j);
            case (j)
                0: return 65536;  1: return 62757;  2: return 60097;  3: return 57549;
                4: return 55108;  5: return 52773;  6: return 50535;  7: return 48392;
                8: return 46341;  9: return 44376;  10: return 42495; 11: return 40693;
                12: return 38968; 13: return 37316; 14: return 35734; 15: return 34219;
                default: return 32768;
            endcase
        endfunction

        function logic [15:0] gauss_weight(int unsigned node);
            logic [63:0] pos, d, sp, t, x, y, k, f, r, m, tj, tj1;
            int j;
            pos = 64'(node) * node_spacing;
            d = (pos >= peak_height) ? pos - peak_height : 64'(peak_height) - pos;
            sp = (spread == 0) ? 64'd1 : 64'(spread);
            t = (d << 16) / sp;
            if (t >= (64'd4 << 16)) return 16'd0;
            x = (t * t) >> 16;
            y = (x * 94548 + 32768) >> 16;
            k = y >> 16;
            f = y & 64'hFFFF;
            j = int'(f >> 12);
            r = f & 64'hFFF;
            tj = pow2_entry(j);
            tj1 = pow2_entry(j + 1);
            m = tj - (((tj - tj1) * r + 2048) >> 12);
            if (k == 0) return (m > 65535) ? 16'hFFFF : m[15:0];
            if (k >= 17) return 16'd0;
            m = (m + (64'd1 << (k - 1))) >> k;
            return (m > 65535) ? 16'hFFFF : m[15:0];
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] index, logic [15:0] value);
            case (index)
                REG_PEAK:    peak_height = value;
                REG_SPREAD:  spread = value;
                REG_SPACING: node_spacing = value;
                REG_AREA:    leaf_area = value;
                REG_COUNT:   node_count = value[6:0];
                default: ;
            endcase
        endfunction

        function void note_request(logic request);
            int unsigned n;
            logic [63:0] s, q, num, dens, c;
            t_density e;
            if (!request) return;
            n = node_count;
            if (n < 3) n = 3;
            if (n > 64) n = 64;
            s = 0;
            for (int unsigned i = 0; i < n; i++) begin
                weight_store[i] = gauss_weight(i);
                c = i[0] ? 64'd4 : 64'd2;
                if (i == 0 || i == n - 1) c = c - 1;
                s = s + c * weight_store[i];
            end
            integral_acc = s[31:0];
            q = 64'(node_spacing) * integral_acc;
            for (int unsigned i = 0; i < n; i++) begin
                dens = 0;
                if (q != 0) begin
                    num = 64'(leaf_area) * weight_store[i] * 768;
                    dens = (num + q / 2) / q;
                    if (dens > 65535) dens = 65535;
                end
                e.node_index = i[5:0];
                e.density = dens[15:0];
                e.last = (i == n - 1);
                pending.push_back(e);
            end
        endfunction

        function void check_density(logic [5:0] idx, logic [15:0] dens, logic last);
            t_density e;
            if (pending.size() == 0) begin
                $error("unexpected transaction: node_index %0d density %0d", idx, dens);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (idx !== e.node_index) begin
                $error("node_index expected %0d actual %0d", e.node_index, idx);
                errors++;
            end
            if (dens !== e.density) begin
                $error("density expected %0d actual %0d", e.density, dens);
                errors++;
            end
            if (last !== e.last) begin
                $error("last expected %0d actual %0d", e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 request = 1'b0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [5:0]           node_index;
    logic [15:0]          density;
    logic                 last;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_PEAK;
    logic [CFG_W-1:0]     cfg_data = '0;

    int                   send_idle = 0;
    int                   recv_idle = 0;
    longint               cycles = 0;
    profile_scoreboard    sb;

    gaussian_profile_normalizer u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_stall(in_stall), .i_request(request),
        .o_valid(out_valid), .i_stall(out_stall),
        .o_node_index(node_index), .o_density(density), .o_last(last),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > 64'd40000000) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            sb.check_density(node_index, density, last);
    end

    always @(negedge clk) begin
        if (!rst_n) out_stall <= 1'b0;
        else if (recv_idle > 0 && $urandom_range(99) < recv_idle) out_stall <= 1'b1;
        else out_stall <= 1'b0;
    end

    // valid stays high after the task until a later send_request idle step or drain lowers it
    task automatic send_request(logic req);
        while (send_idle > 0 && $urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            request <= 1'($urandom_range(1));
            @(negedge clk);
        end
        in_valid <= 1'b1;
        request <= req;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_request(req);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        request <= 1'($urandom_range(1));
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] index, logic [15:0] value);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        sb.write_reg(index, value);
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic random_setting();
        write_cfg(REG_PEAK, 16'($urandom_range(65535)));
        write_cfg(REG_SPREAD, 16'(($urandom_range(3) == 0) ? $urandom_range(65535)
                                                             : $urandom_range(4096)));
        write_cfg(REG_SPACING, 16'($urandom_range(1, 1024)));
        write_cfg(REG_AREA, 16'($urandom_range(65535)));
        write_cfg(REG_COUNT, 16'(($urandom_range(7) == 0) ? $urandom_range(127)
                                                            : $urandom_range(3, 12)));
    endtask

    initial begin
        sb = new();
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: defaults, then register extremes and special cases
        send_request(1'b1);
        send_request(1'b0);
        drain();
        write_cfg(REG_COUNT, 16'd0);
        write_cfg(REG_SPREAD, 16'd0);
        write_cfg(REG_PEAK, 16'd0);
        send_request(1'b1);
        drain();
        write_cfg(REG_COUNT, 16'd127);
        write_cfg(REG_SPREAD, 16'hFFFF);
        write_cfg(REG_PEAK, 16'hFFFF);
        write_cfg(REG_SPACING, 16'hFFFF);
        write_cfg(REG_AREA, 16'hFFFF);
        send_request(1'b1);
        drain();
        write_cfg(REG_COUNT, 16'd4);
        write_cfg(REG_SPACING, 16'd0);
        send_request(1'b1);
        drain();
        write_cfg(REG_SPACING, 16'd1);
        write_cfg(REG_SPREAD, 16'd1);
        write_cfg(REG_PEAK, 16'h8000);
        write_cfg(REG_AREA, 16'd0);
        send_request(1'b1);
        drain();
        write_cfg(REG_UNUSED, 16'h1234);
        write_cfg(REG_AREA, 16'h5A5A);
        write_cfg(REG_PEAK, 16'd300);
        write_cfg(REG_SPREAD, 16'd200);
        write_cfg(REG_SPACING, 16'd100);
        write_cfg(REG_COUNT, 16'd5);
        send_request(1'b1);
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle = (phase == 0) ? 34 : (phase == 1) ? 77 : 0;
            recv_idle = (phase == 0) ? 77 : (phase == 1) ? 34 : 0;
            for (int b = 0; b < 8; b++) begin
                random_setting();
                for (int k = 0; k < 6; k++) send_request($urandom_range(7) != 0);
                drain();
            end
        end
        drain();
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
